### src/sspg_pkg.sv
// ----------------------------------------------------------------------------
// Stepper step pulse generator package
// Shared types, constants and codes for the step pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sspg_pkg;

	// Field widths.
	localparam int PERIOD_W = 16;
	localparam int POS_W    = 32;
	localparam int CNT_W    = 16;
	localparam int SPEED_W  = 16;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	// Period numerator: 4000 timer ticks times 256 for the Q8.8 speed.
	localparam int NUM_W = 20;
	localparam logic [NUM_W-1:0] PERIOD_NUM = 20'd1024000;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
	localparam logic [CNT_W-1:0] STALL_MAX = 16'hFFFF;

	// One quotient bit is produced per divider step.
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Reset values.
	localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD = 16'd5;
	localparam logic [POS_W-1:0]    RST_UPPER      = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0]    RST_LOWER      = 32'h8000_0000;
	localparam logic [CNT_W-1:0]    RST_WATCHDOG   = 16'd500;
	localparam logic [PERIOD_W-1:0] RST_PERIOD     = 16'd5;

	// Input word kinds.
	localparam logic ACT_SET_SPEED = 1'b0;
	localparam logic ACT_TICK      = 1'b1;

	// Direction codes.
	localparam logic DIR_REVERSE = 1'b0;
	localparam logic DIR_FORWARD = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG   = 2'd3;

	typedef struct packed {
		logic [PERIOD_W-1:0]     min_period;
		logic signed [POS_W-1:0] upper_limit;
		logic signed [POS_W-1:0] lower_limit;
		logic [CNT_W-1:0]        watchdog;
	} cfg_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]     period;
		logic                    dir;
		logic signed [POS_W-1:0] steps;
		logic [CNT_W-1:0]        stall_cnt;
		logic [CNT_W-1:0]        clamp_cnt;
	} motor_state_t;

	typedef struct packed {
		logic                done;
		logic [PERIOD_W-1:0] quotient;
	} div_res_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DIV
	} fsm_t;

endpackage

`default_nettype wire

### src/sspg_if.sv
// ----------------------------------------------------------------------------
// Stepper step pulse generator channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sspg_cmd_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic signed [15:0]        speed;

	modport source (output valid, output action, output speed, input ready);
	modport sink (input valid, input action, input speed, output ready);
endinterface

interface sspg_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      step_pulse;
	logic                      direction;
	logic [15:0]               period;
	logic signed [31:0]        position_steps;
	logic [15:0]               clamp_count;
	logic                      stalled;

	modport source (output valid, output step_pulse, output direction, output period,
		output position_steps, output clamp_count, output stalled, input ready);
	modport sink (input valid, input step_pulse, input direction, input period,
		input position_steps, input clamp_count, input stalled, output ready);
endinterface

`default_nettype wire

### src/sspg_div.sv
// ----------------------------------------------------------------------------
// Period divider
// Restoring divider that forms 1024000 / divisor one quotient bit per cycle
// and saturates the quotient to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sspg_div (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire [sspg_pkg::PERIOD_W-1:0]   divisor,
	output sspg_pkg::div_res_t             res
);
	import sspg_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [PERIOD_W-1:0]   dsr_q;
	logic [PERIOD_W-1:0]   rem_q;
	logic [NUM_W-1:0]      dvd_q;
	logic [NUM_W-1:0]      quo_q;

	logic [PERIOD_W:0]     trial;
	logic                  fits;
	logic [PERIOD_W:0]     diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[NUM_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath. A zero divisor makes every step fit, so the quotient saturates.
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			dvd_q <= PERIOD_NUM;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	// Saturated result.
	always_comb begin
		res.done     = done_q;
		res.quotient = (|quo_q[NUM_W-1:PERIOD_W]) ? PERIOD_MAX : quo_q[PERIOD_W-1:0];
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a running division");
	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != '0) |=> busy_q)
		else $error("divider stopped early");

endmodule

`default_nettype wire

### src/sspg_tick.sv
// ----------------------------------------------------------------------------
// Tick update
// Works out the state after one timer tick: period clamp, soft limits,
// watchdog and the step itself.
// ----------------------------------------------------------------------------
`default_nettype none

module sspg_tick (
	input  sspg_pkg::cfg_t          cfg,
	input  sspg_pkg::motor_state_t  cur,
	output sspg_pkg::motor_state_t  nxt,
	output logic                    pulse
);
	import sspg_pkg::*;

	logic clamp;
	logic blocked;
	logic expired;

	always_comb begin
		nxt   = cur;
		pulse = 1'b0;

		// Raise a too-short period to the minimum and count it.
		clamp = cur.period < cfg.min_period;
		if (clamp) begin
			nxt.period    = cfg.min_period;
			nxt.clamp_cnt = cur.clamp_cnt + 1'b1;
		end

		// Soft limits compare the live step count.
		if (cur.dir == DIR_FORWARD) begin
			blocked = cur.steps > cfg.upper_limit;
		end else begin
			blocked = cur.steps < cfg.lower_limit;
		end

		// Watchdog counts saturating; it judges the value before the count.
		expired = cur.stall_cnt > cfg.watchdog;
		if (!blocked) begin
			if (cur.stall_cnt != STALL_MAX) begin
				nxt.stall_cnt = cur.stall_cnt + 1'b1;
			end
			if (!expired) begin
				pulse = 1'b1;
				if (cur.dir == DIR_FORWARD) begin
					nxt.steps = cur.steps + 1'b1;
				end else begin
					nxt.steps = cur.steps - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/stepper_step_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// Stepper step pulse generator core
// Step/direction generator driven by set-speed and timer-tick command words.
// ----------------------------------------------------------------------------
// A tick word is handled combinationally: its result word is registered on
// the cycle after acceptance. A set-speed word runs the shared restoring
// divider, one quotient bit per clock; its result word is registered once
// the divider signals done; no command word is taken meanwhile. A new word is
// accepted while the previous result is being taken from the output register.
// Zero speed gives the full period of 65535 in the forward direction.
`default_nettype none

module stepper_step_pulse_generator_core (
	input  wire                              clk,
	input  wire                              arst_n,
	sspg_cmd_if.sink                         cmd,
	sspg_rsp_if.source                       rsp,
	input  wire                              cfg_we,
	input  wire [sspg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [sspg_pkg::CFG_W-1:0]        cfg_data
);
	import sspg_pkg::*;

	fsm_t          state_q;
	fsm_t          state_nxt;
	cfg_t          cfg_q;
	motor_state_t  mst_q;
	motor_state_t  tick_nxt;
	logic          tick_pulse;
	logic          pend_dir_q;

	logic          cmd_ready;
	logic          cmd_take;
	logic          take_tick;
	logic          div_start;
	logic          speed_neg;
	logic [PERIOD_W-1:0] speed_mag;
	div_res_t      div_res;

	logic                    rsp_valid_q;
	logic                    rsp_pulse_q;
	logic                    rsp_dir_q;
	logic [PERIOD_W-1:0]     rsp_period_q;
	logic signed [POS_W-1:0] rsp_pos_q;
	logic [CNT_W-1:0]        rsp_clamp_q;
	logic                    rsp_stalled_q;

	// Handshake: idle and the output register free or being drained.
	always_comb begin
		cmd_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
		cmd_take  = cmd.valid && cmd_ready;
		take_tick = cmd_take && (cmd.action == ACT_TICK);
		div_start = cmd_take && (cmd.action == ACT_SET_SPEED);
		speed_neg = cmd.speed[SPEED_W-1];
		speed_mag = speed_neg ? PERIOD_W'(-cmd.speed) : PERIOD_W'(cmd.speed);
	end

	assign cmd.ready = cmd_ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (div_start) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_period  <= RST_MIN_PERIOD;
			cfg_q.upper_limit <= RST_UPPER;
			cfg_q.lower_limit <= RST_LOWER;
			cfg_q.watchdog    <= RST_WATCHDOG;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_PERIOD: cfg_q.min_period  <= cfg_data[PERIOD_W-1:0];
				REG_UPPER:      cfg_q.upper_limit <= cfg_data[POS_W-1:0];
				REG_LOWER:      cfg_q.lower_limit <= cfg_data[POS_W-1:0];
				REG_WATCHDOG:   cfg_q.watchdog    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared divider and tick logic.
	sspg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (speed_mag),
		.res     (div_res)
	);

	sspg_tick u_tick (
		.cfg   (cfg_q),
		.cur   (mst_q),
		.nxt   (tick_nxt),
		.pulse (tick_pulse)
	);

	// Motor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q.period    <= RST_PERIOD;
			mst_q.dir       <= DIR_REVERSE;
			mst_q.steps     <= '0;
			mst_q.stall_cnt <= '0;
			mst_q.clamp_cnt <= '0;
		end else if (take_tick) begin
			mst_q <= tick_nxt;
		end else if (div_res.done) begin
			mst_q.period    <= div_res.quotient;
			mst_q.dir       <= pend_dir_q;
			mst_q.stall_cnt <= '0;
		end
	end

	// Direction of a set-speed word waits here while the divider runs.
	always_ff @(posedge clk) begin
		if (div_start) begin
			pend_dir_q <= speed_neg ? DIR_REVERSE : DIR_FORWARD;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take_tick || div_res.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			rsp_pulse_q   <= tick_pulse;
			rsp_dir_q     <= tick_nxt.dir;
			rsp_period_q  <= tick_nxt.period;
			rsp_pos_q     <= tick_nxt.steps;
			rsp_clamp_q   <= tick_nxt.clamp_cnt;
			rsp_stalled_q <= tick_nxt.stall_cnt > cfg_q.watchdog;
		end else if (div_res.done) begin
			rsp_pulse_q   <= 1'b0;
			rsp_dir_q     <= pend_dir_q;
			rsp_period_q  <= div_res.quotient;
			rsp_pos_q     <= mst_q.steps;
			rsp_clamp_q   <= mst_q.clamp_cnt;
			rsp_stalled_q <= 1'b0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.step_pulse     = rsp_pulse_q;
	assign rsp.direction      = rsp_dir_q;
	assign rsp.period         = rsp_period_q;
	assign rsp.position_steps = rsp_pos_q;
	assign rsp.clamp_count    = rsp_clamp_q;
	assign rsp.stalled        = rsp_stalled_q;

	a_no_take_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !cmd_ready)
		else $error("command word taken during a division");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV) && (!rsp_valid_q))
		else $error("division finished outside its slot");
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_tick |=> rsp_valid_q && (mst_q.period == rsp_period_q))
		else $error("tick word gave no result");
	a_speed_result: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |=> rsp_valid_q && !rsp_pulse_q && (state_q == ST_IDLE))
		else $error("set-speed word gave no result");

endmodule

`default_nettype wire
